[hdl/slcbg_pkg.sv]
// shared types, constants and the cordic angle function for the chaotic byte generator
// no dependencies
`timescale 1ns / 1ps

package slcbg_pkg;

    localparam int FRAC_BITS = 32;
    localparam int OPND_W    = FRAC_BITS + 1;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int CX_W      = FRAC_BITS + 4;
    localparam int Z_W       = FRAC_BITS + 2;
    localparam int KIDX_W    = 6;

    localparam logic [FRAC_BITS-1:0] GAIN    = 32'h9B74EDA8;
    localparam logic [FRAC_BITS-1:0] INV2PI  = 32'h28BE60DB;
    localparam logic [FRAC_BITS:0]   ONE     = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS-1:0] HALF    = {1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic [FRAC_BITS-1:0] QUARTER = {2'b01, {(FRAC_BITS-2){1'b0}}};

    localparam logic [1:0] REG_RATIO = 2'd0;
    localparam logic [1:0] REG_SCALE = 2'd1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [31:0] ANGLE_TBL [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T,
        ST_P,
        ST_Q,
        ST_SINE,
        ST_M,
        ST_SUM,
        ST_B1,
        ST_B2,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              en;
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
    } mul_req_t;

    function automatic logic [FRAC_BITS-1:0] cordic_angle(input logic [KIDX_W-1:0] k);
        logic [FRAC_BITS-1:0] res;
        if (k < KIDX_W'(16))
        begin
            res = ANGLE_TBL[k[3:0]];
        end
        else
        begin
            res = INV2PI >> k;
        end
        return res;
    endfunction

endpackage

[hdl/sine_logistic_chaotic_byte_gen.sv]
// sine-logistic chaotic map generator: sequencer, registers and output stage
// a step item runs through states T, P, Q, SINE, M, SUM, B1, B2 and OUT to its result
// in_ready is high only in idle, so no new item is accepted while a step item is in progress
// a load item sets the state point and gives no result
// reset: state point cleared, ratio to one half, scale to 2^32, no result pending
// depends on slcbg_pkg, slcbg_mul, slcbg_cordic
`timescale 1ns / 1ps

module sine_logistic_chaotic_byte_gen
    import slcbg_pkg::*;
#(
    parameter int SINE_STEPS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [31:0] seed,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] point,
    output logic [7:0]  out_byte,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    state_t state_reg, state_next;

    logic [31:0] ratio_reg;
    logic [47:0] scale_reg;
    logic [31:0] cur_reg;
    logic [31:0] q_reg;
    logic [31:0] np_reg;
    logic [7:0]  b1_reg;
    logic [31:0] point_reg;
    logic [7:0]  byte_reg;
    logic        out_valid_reg;

    mul_req_t          mreq;
    logic [PROD_W-1:0] prod;
    logic              sine_start;
    logic              sine_done;
    logic [FRAC_BITS:0] sine;

    logic [31:0] u;
    logic [31:0] t_raw;
    logic [31:0] t_fold;
    logic [31:0] sum;
    logic        out_free;
    logic        in_acc;

    assign u      = (cur_reg < HALF) ? cur_reg : 32'(ONE - {1'b0, cur_reg});
    assign t_raw  = prod[63:32];
    assign t_fold = (t_raw > QUARTER) ? (HALF - t_raw) : t_raw;
    assign sum    = prod[63:32] + {q_reg[29:0], 2'b00};
    assign out_free = !out_valid_reg || out_ready;
    assign in_acc   = in_valid && in_ready;

    slcbg_mul u_mul (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    slcbg_cordic #(
        .SINE_STEPS (SINE_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sine_start),
        .angle (t_fold),
        .done  (sine_done),
        .sine  (sine)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && command == CMD_STEP)
                begin
                    state_next = ST_T;
                end
            end
            ST_T:    state_next = ST_P;
            ST_P:    state_next = ST_Q;
            ST_Q:    state_next = ST_SINE;
            ST_SINE:
            begin
                if (sine_done)
                begin
                    state_next = ST_M;
                end
            end
            ST_M:    state_next = ST_SUM;
            ST_SUM:  state_next = ST_B1;
            ST_B1:   state_next = ST_B2;
            ST_B2:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        mreq       = '0;
        sine_start = 1'b0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_T:
            begin
                mreq.en = 1'b1;
                mreq.a  = OPND_W'(ratio_reg);
                mreq.b  = OPND_W'(u);
            end
            ST_P:
            begin
                mreq.en    = 1'b1;
                mreq.a     = OPND_W'(cur_reg);
                mreq.b     = ONE - {1'b0, cur_reg};
                sine_start = 1'b1;
            end
            ST_Q:
            begin
                mreq.en = 1'b1;
                mreq.a  = ONE - {1'b0, ratio_reg};
                mreq.b  = OPND_W'(prod[63:32]);
            end
            ST_M:
            begin
                mreq.en = 1'b1;
                mreq.a  = OPND_W'(ratio_reg);
                mreq.b  = sine;
            end
            ST_B1:
            begin
                mreq.en = 1'b1;
                mreq.a  = OPND_W'(np_reg);
                mreq.b  = OPND_W'(scale_reg[31:0]);
            end
            ST_B2:
            begin
                mreq.en = 1'b1;
                mreq.a  = OPND_W'(np_reg);
                mreq.b  = OPND_W'(scale_reg[47:32]);
            end
            default:
            begin
                mreq       = '0;
                sine_start = 1'b0;
                in_ready   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ratio_reg     <= 32'h80000000;
            scale_reg     <= 48'h0001_0000_0000;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == REG_RATIO)
            begin
                ratio_reg <= cfg_data[31:0];
            end
            if (cfg_we && cfg_index == REG_SCALE)
            begin
                scale_reg <= cfg_data;
            end
            if (in_acc && command == CMD_LOAD)
            begin
                cur_reg <= seed;
            end
            else if (state_reg == ST_SUM)
            begin
                cur_reg <= sum;
            end
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SINE)
        begin
            q_reg <= prod[63:32];
        end
        if (state_reg == ST_SUM)
        begin
            np_reg <= sum;
        end
        if (state_reg == ST_B2)
        begin
            b1_reg <= prod[39:32];
        end
        if (state_reg == ST_OUT && out_free)
        begin
            point_reg <= np_reg;
            byte_reg  <= b1_reg + prod[7:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign point     = point_reg;
    assign out_byte  = byte_reg;

`ifndef ASSERT_OFF
    a_done_in_sine: assert property (@(posedge clk) disable iff (!rst_n)
        sine_done |-> state_reg == ST_SINE)
        else $error("sine finished outside its wait state");

    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output state");

    a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && command == CMD_STEP) |=> state_reg == ST_T)
        else $error("step item did not start the sequence");

    a_load_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && command == CMD_LOAD) |=> (cur_reg == $past(seed) && state_reg == ST_IDLE))
        else $error("load item did not set the point");
`endif

endmodule

[hdl/slcbg_mul.sv]
// shared unsigned multiplier with registered product
// depends on slcbg_pkg
`timescale 1ns / 1ps

module slcbg_mul
    import slcbg_pkg::*;
(
    input  logic              clk,
    input  mul_req_t          req,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= req.a * req.b;
        end
    end

    assign prod = prod_reg;

endmodule

[hdl/slcbg_cordic.sv]
// iterative cordic sine over turns, one rotation per cycle, result clamped to [0, 1]
// depends on slcbg_pkg
`timescale 1ns / 1ps

module slcbg_cordic
    import slcbg_pkg::*;
#(
    parameter int SINE_STEPS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [FRAC_BITS-1:0] angle,
    output logic                 done,
    output logic [FRAC_BITS:0]   sine
);

    localparam int KW = $clog2(SINE_STEPS);
    localparam logic [KW-1:0] K_LAST = KW'(SINE_STEPS - 1);

    logic                  run_reg, run_next;
    logic                  clamp_reg, clamp_next;
    logic                  done_reg, done_next;
    logic [KW-1:0]         k_reg, k_next;
    logic signed [CX_W-1:0] cx_reg, cx_next;
    logic signed [CX_W-1:0] cy_reg, cy_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic [FRAC_BITS:0]    sine_reg, sine_next;

    logic signed [CX_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  ang;

    assign dx  = cy_reg >>> k_reg;
    assign dy  = cx_reg >>> k_reg;
    assign ang = Z_W'(cordic_angle(KIDX_W'(k_reg)));

    always_comb
    begin
        run_next   = run_reg;
        clamp_next = 1'b0;
        done_next  = 1'b0;
        k_next     = k_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        z_next     = z_reg;
        sine_next  = sine_reg;
        if (start)
        begin
            run_next = 1'b1;
            k_next   = '0;
            cx_next  = CX_W'(GAIN);
            cy_next  = '0;
            z_next   = Z_W'(angle);
        end
        else if (run_reg)
        begin
            if (!z_reg[Z_W-1])
            begin
                cx_next = cx_reg - dx;
                cy_next = cy_reg + dy;
                z_next  = z_reg - ang;
            end
            else
            begin
                cx_next = cx_reg + dx;
                cy_next = cy_reg - dy;
                z_next  = z_reg + ang;
            end
            k_next = k_reg + KW'(1);
            if (k_reg == K_LAST)
            begin
                run_next   = 1'b0;
                clamp_next = 1'b1;
            end
        end
        if (clamp_reg)
        begin
            done_next = 1'b1;
            if (cy_reg[CX_W-1])
            begin
                sine_next = '0;
            end
            else if (cy_reg > $signed({{(CX_W-FRAC_BITS-1){1'b0}}, ONE}))
            begin
                sine_next = ONE;
            end
            else
            begin
                sine_next = cy_reg[FRAC_BITS:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            clamp_reg <= 1'b0;
            done_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            clamp_reg <= clamp_next;
            done_reg  <= done_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        z_reg    <= z_next;
        sine_reg <= sine_next;
    end

    assign done = done_reg;
    assign sine = sine_reg;

endmodule

[dv/tb.sv]
// testbench for sine_logistic_chaotic_byte_gen: random and directed load/step items
// checked against an in-bench map predictor
// depends on slcbg_pkg and the sine_logistic_chaotic_byte_gen rtl
`timescale 1ns / 1ps

module tb;
    import slcbg_pkg::*;

    localparam int SINE_STEPS       = 32;
    localparam int SETTLE_CYCLES    = 60;
    localparam int QUIET_LIMIT      = 4000;
    localparam int LONG_HOLD_CYCLES = 400;

    localparam logic [1:0] REG_SPARE_2 = 2'd2;
    localparam logic [1:0] REG_SPARE_3 = 2'd3;

    localparam logic [63:0] UNIT        = 64'h1_0000_0000;
    localparam logic [31:0] CORDIC_GAIN = 32'h9B74EDA8;
    localparam logic [31:0] INV_TWO_PI  = 32'h28BE60DB;
    localparam logic [31:0] TURN_ANGLE [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    typedef struct {
        logic        command;
        logic [31:0] seed;
    } map_item_t;

    typedef struct {
        logic [31:0] point;
        logic [7:0]  out_byte;
    } map_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        command   = CMD_LOAD;
    logic [31:0] seed      = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] point;
    logic [7:0]  out_byte;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = REG_RATIO;
    logic [47:0] cfg_data  = '0;

    map_item_t   pending_items [$];
    map_result_t expected_results [$];

    logic [31:0] map_state  = '0;
    logic [31:0] ratio_reg  = 32'h8000_0000;
    logic [47:0] scale_reg  = 48'h1_0000_0000;

    int          queued_count   = 0;
    int          accepted_count = 0;
    int          errors         = 0;
    int          gap_left       = 0;
    int          stall_left     = 0;
    int          quiet_cycles   = 0;
    logic        tx_idle_en     = 1'b1;
    logic        rx_idle_en     = 1'b1;
    logic        long_hold_req  = 1'b0;
    logic        long_hold_done = 1'b0;

    sine_logistic_chaotic_byte_gen #(
        .SINE_STEPS (SINE_STEPS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .seed      (seed),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .point     (point),
        .out_byte  (out_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = ~clk;
    end

    // truncated q32.32 product
    function automatic logic [63:0] frac_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = a * b;
        return prod[95:32];
    endfunction

    // sine of an angle in turns, angle in [0, 1/2)
    function automatic logic [63:0] sine_of_turns(input logic [63:0] turns);
        logic [63:0] t;
        logic [63:0] res;
        longint      cx;
        longint      cy;
        longint      z;
        longint      dx;
        longint      dy;
        longint      ang;
        int          k;
        t = turns;
        if (t > UNIT / 4)
        begin
            t = UNIT / 2 - t;
        end
        cx = {32'd0, CORDIC_GAIN};
        cy = 0;
        z  = t;
        for (k = 0; k < SINE_STEPS; k++)
        begin
            dx  = cy >>> k;
            dy  = cx >>> k;
            ang = {32'd0, (k < 16) ? TURN_ANGLE[4'(k)] : (INV_TWO_PI >> k)};
            if (z >= 0)
            begin
                cx = cx - dx;
                cy = cy + dy;
                z  = z - ang;
            end
            else
            begin
                cx = cx + dx;
                cy = cy - dy;
                z  = z + ang;
            end
        end
        if (cy < 0)
        begin
            res = '0;
        end
        else if (64'(cy) > UNIT)
        begin
            res = UNIT;
        end
        else
        begin
            res = 64'(cy);
        end
        return res;
    endfunction

    function automatic map_result_t advance_map(input logic [31:0] x_now,
                                                input logic [31:0] ratio_now,
                                                input logic [47:0] scale_now);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] u;
        logic [63:0] s;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] total;
        logic [79:0] scaled;
        map_result_t res;
        x = {32'd0, x_now};
        r = {32'd0, ratio_now};
        u = (x < UNIT / 2) ? x : UNIT - x;
        s = sine_of_turns(frac_mul(r, u));
        p = frac_mul(x, UNIT - x);
        q = frac_mul(UNIT - r, p);
        total = (frac_mul(r, s) + (q << 2)) & (UNIT - 1);
        res.point = total[31:0];
        scaled = {48'd0, res.point} * {32'd0, scale_now};
        res.out_byte = scaled[39:32];
        return res;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin : sender
        map_item_t   next_item;
        map_result_t res;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (command == CMD_LOAD)
                begin
                    map_state = seed;
                end
                else
                begin
                    res = advance_map(map_state, ratio_reg, scale_reg);
                    map_state = res.point;
                    expected_results = {expected_results, res};
                end
                accepted_count = accepted_count + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (tx_idle_en && $urandom_range(0, 5) == 0)
                begin
                    gap_left <= $urandom_range(0, 16);
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    next_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    command  <= next_item.command;
                    seed     <= next_item.seed;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : receiver
        map_result_t want;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected item: point %h, out_byte %h", point, out_byte);
                    errors = errors + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (point !== want.point)
                    begin
                        $error("point: expected %h, actual %h", want.point, point);
                        errors = errors + 1;
                    end
                    if (out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, actual %h", want.out_byte, out_byte);
                        errors = errors + 1;
                    end
                end
            end
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done <= 1'b1;
                stall_left     <= LONG_HOLD_CYCLES - 1;
                out_ready      <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left <= $urandom_range(0, 16);
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_item(input logic cmd, input logic [31:0] value);
        map_item_t item;
        item.command = cmd;
        item.seed    = value;
        pending_items = {pending_items, item};
        queued_count = queued_count + 1;
    endtask

    task automatic add_random_items(input int count);
        logic [31:0] value;
        int          i;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                case ($urandom_range(0, 7))
                    0: value = 32'h0000_0000;
                    1: value = 32'hFFFF_FFFF;
                    2: value = 32'h8000_0000;
                    3: value = 32'h7FFF_FFFF;
                    default: value = $urandom;
                endcase
                add_item(CMD_LOAD, value);
            end
            else
            begin
                add_item(CMD_STEP, $urandom);
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_RATIO)
        begin
            ratio_reg = data[31:0];
        end
        else if (idx == REG_SCALE)
        begin
            scale_reg = data;
        end
    endtask

    task automatic wait_idle();
        while (accepted_count != queued_count || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int ph;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: step before any load, field extremes, half point, back-to-back loads
        add_item(CMD_STEP, 32'h0000_0000);
        add_item(CMD_LOAD, 32'h0000_0000);
        add_item(CMD_STEP, 32'hFFFF_FFFF);
        add_item(CMD_LOAD, 32'hFFFF_FFFF);
        add_item(CMD_STEP, 32'h0000_0000);
        add_item(CMD_LOAD, 32'h8000_0000);
        add_item(CMD_STEP, 32'h0000_0000);
        add_item(CMD_LOAD, 32'h7FFF_FFFF);
        add_item(CMD_STEP, 32'h0000_0000);
        add_item(CMD_LOAD, 32'h0000_0001);
        add_item(CMD_STEP, 32'h0000_0000);
        add_item(CMD_LOAD, 32'h4000_0000);
        add_item(CMD_LOAD, 32'h2AAA_AAAA);
        add_item(CMD_STEP, 32'h0000_0000);
        add_item(CMD_STEP, 32'h0000_0000);
        add_item(CMD_STEP, 32'h0000_0000);
        add_random_items(90);
        wait_idle();

        // top ratio folds the sine angle past a quarter turn
        write_reg(REG_RATIO, 48'h0000_FFFF_FFFF);
        write_reg(REG_SCALE, 48'hFFFF_FFFF_FFFF);
        add_item(CMD_LOAD, 32'h7FFF_FFFF);
        add_item(CMD_STEP, 32'h0000_0000);
        add_item(CMD_LOAD, 32'h6000_0000);
        add_item(CMD_STEP, 32'h0000_0000);
        add_random_items(100);
        wait_idle();

        // long output hold-off while the sender keeps offering
        write_reg(REG_RATIO, 48'h0);
        write_reg(REG_SCALE, 48'h1);
        long_hold_req = 1'b1;
        add_random_items(100);
        wait_idle();

        // zero scale gives a zero byte
        write_reg(REG_RATIO, 48'h1);
        write_reg(REG_SCALE, 48'h0);
        add_random_items(80);
        wait_idle();

        // writes to unused register indexes, which the generator ignores, then ratio and scale back to reset values
        write_reg(REG_SPARE_2, 48'({$urandom, $urandom}));
        write_reg(REG_SPARE_3, 48'({$urandom, $urandom}));
        write_reg(REG_RATIO, 48'h0000_8000_0000);
        write_reg(REG_SCALE, 48'h0001_0000_0000);
        tx_idle_en = 1'b0;
        add_random_items(100);
        wait_idle();
        tx_idle_en = 1'b1;

        for (ph = 0; ph < 3; ph++)
        begin
            write_reg(REG_RATIO, {16'd0, $urandom});
            write_reg(REG_SCALE, {16'($urandom), $urandom});
            if (ph == 2)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            add_random_items(125);
            wait_idle();
        end

        if (errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
